>>> hdl/tce_pkg.sv
// Shared definitions for the tiny CPU execute unit.
// Holds the data width and the operation codes; depends on nothing.
`default_nettype none

package tce_pkg;

	localparam int DATA_W = 8;
	localparam int OP_W   = 4;

	typedef logic [DATA_W-1:0] byte_t;

	typedef enum logic [OP_W-1:0] {
		OP_MOV_REG = 4'd0,
		OP_MOV_IMM = 4'd1,
		OP_STORE   = 4'd2,
		OP_LOAD    = 4'd3,
		OP_ADD     = 4'd4,
		OP_SUB     = 4'd5,
		OP_JMP     = 4'd6,
		OP_JEQ     = 4'd7,
		OP_HLT     = 4'd8
	} op_t;

endpackage

`default_nettype wire

>>> hdl/tce_ram.sv
// Generic synchronous RAM: one write port, one or more registered read ports.
// Stand-alone; read data holds while the read enable is low.
`default_nettype none

module tce_ram #(
	parameter int WIDTH    = 8,
	parameter int DEPTH    = 256,
	parameter int RD_PORTS = 1
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr [RD_PORTS],
	output      logic [WIDTH-1:0]                     rdata [RD_PORTS]
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			for (int p = 0; p < RD_PORTS; p++) begin
				rdata[p] <= mem_q[raddr[p]];
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/tiny_cpu_execute_unit_top.sv
// Tiny CPU execute unit: one decoded instruction in, one result transfer out.
// A result becomes valid once its instruction has passed through stage 1 into the output register.
// Throughput: one instruction per cycle when not stalled, set by the read-modify-write of the
// register file RAM and the data memory RAM; the output register decouples the two sides.
// Reset (arst_n, asynchronous, active low) clears PC, flag, pipeline valids and the
// per-entry valid bits; unwritten entries read as zero, so no clearing pass is needed.
`default_nettype none

module tiny_cpu_execute_unit_top #(
	parameter int MEMORY_DEPTH   = 256,
	parameter int REGISTER_COUNT = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [3:0]  operation,
	input  wire logic [1:0]  dest_select,
	input  wire logic [1:0]  src_select,
	input  wire logic [7:0]  operand_byte,

	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [7:0]  next_pc,
	output      logic        equal_flag_out,
	output      logic        halted,
	output      logic [7:0]  written_value
);

	localparam int AW = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;
	localparam int RW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

	// Register selects are two bits wide and wrap modulo the register count.
	// Since a select is below four and the count is at least two, one conditional
	// subtract is enough.
	function automatic logic [RW-1:0] reg_idx(input logic [1:0] sel);
		logic [4:0] t;
		t = {3'b000, sel};
		if (t >= 5'(REGISTER_COUNT)) begin
			t = t - 5'(REGISTER_COUNT);
		end
		return t[RW-1:0];
	endfunction

	// Memory addresses wrap modulo the depth. The byte is below sixteen times the
	// smallest depth, so four restoring steps (depth times 8, 4, 2, 1) give the remainder.
	function automatic logic [AW-1:0] mem_idx(input logic [7:0] addr);
		logic [11:0] t;
		t = {4'b0000, addr};
		for (int k = 3; k >= 0; k--) begin
			if (t >= 12'(MEMORY_DEPTH << k)) begin
				t = t - 12'(MEMORY_DEPTH << k);
			end
		end
		return t[AW-1:0];
	endfunction

	// Handshake.
	logic accept;
	logic advance;
	logic v_s1;

	assign advance  = v_s1 && (!out_valid || !out_stall);
	assign in_stall = v_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Decoded indices of the incoming instruction.
	logic [RW-1:0] d_in;
	logic [RW-1:0] s_in;
	logic [AW-1:0] a_in;

	assign d_in = reg_idx(dest_select);
	assign s_in = reg_idx(src_select);
	assign a_in = mem_idx(operand_byte);

	// Stage 1 holds the instruction while the RAM read data is available.
	tce_pkg::op_t   op_s1;
	logic [RW-1:0]  d_s1;
	logic [RW-1:0]  s_s1;
	logic [AW-1:0]  a_s1;
	tce_pkg::byte_t imm_s1;

	// Bypass: the RAM read for an instruction is issued at the same edge that
	// commits the previous instruction's write, so the RAM returns stale data
	// when the addresses match. These registers carry the written value instead.
	logic           fwd_d_s1;
	logic           fwd_s_s1;
	logic           fwd_m_s1;
	tce_pkg::byte_t byp_s1;

	// Architectural state outside the RAMs.
	logic [7:0]                pc_q;
	logic                      flag_q;
	logic [REGISTER_COUNT-1:0] rf_valid_q;
	logic [MEMORY_DEPTH-1:0]   mem_valid_q;

	// Register file RAM: two read ports (destination and source operands).
	logic [RW-1:0]  rf_raddr [2];
	tce_pkg::byte_t rf_rdata [2];
	logic           rf_wr;

	// Data memory RAM.
	logic [AW-1:0]  mem_raddr [1];
	tce_pkg::byte_t mem_rdata [1];
	logic           mem_wr;

	// Execute results.
	tce_pkg::byte_t wv_c;
	logic [7:0]     pc_c;
	logic           flag_c;
	logic           halt_c;
	logic           rf_we_c;
	logic           mem_we_c;

	assign rf_raddr[0]  = d_in;
	assign rf_raddr[1]  = s_in;
	assign mem_raddr[0] = a_in;

	assign rf_wr  = advance && rf_we_c;
	assign mem_wr = advance && mem_we_c;

	tce_ram #(
		.WIDTH    (tce_pkg::DATA_W),
		.DEPTH    (REGISTER_COUNT),
		.RD_PORTS (2)
	) u_rf_ram (
		.clk   (clk),
		.we    (rf_wr),
		.waddr (d_s1),
		.wdata (wv_c),
		.re    (accept),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	tce_ram #(
		.WIDTH    (tce_pkg::DATA_W),
		.DEPTH    (MEMORY_DEPTH),
		.RD_PORTS (1)
	) u_dmem_ram (
		.clk   (clk),
		.we    (mem_wr),
		.waddr (a_s1),
		.wdata (wv_c),
		.re    (accept),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Operand selection: the bypass wins, then an entry never written reads as zero.
	tce_pkg::byte_t rd_val;
	tce_pkg::byte_t rs_val;
	tce_pkg::byte_t mem_val;

	always_comb begin
		if (fwd_d_s1) begin
			rd_val = byp_s1;
		end else if (rf_valid_q[d_s1]) begin
			rd_val = rf_rdata[0];
		end else begin
			rd_val = '0;
		end

		if (fwd_s_s1) begin
			rs_val = byp_s1;
		end else if (rf_valid_q[s_s1]) begin
			rs_val = rf_rdata[1];
		end else begin
			rs_val = '0;
		end

		if (fwd_m_s1) begin
			mem_val = byp_s1;
		end else if (mem_valid_q[a_s1]) begin
			mem_val = mem_rdata[0];
		end else begin
			mem_val = '0;
		end
	end

	// Execute. The flag is only ever set, never cleared, apart from reset.
	always_comb begin
		wv_c     = '0;
		pc_c     = pc_q + 8'd1;
		flag_c   = flag_q;
		halt_c   = 1'b0;
		rf_we_c  = 1'b0;
		mem_we_c = 1'b0;
		unique case (op_s1)
			tce_pkg::OP_MOV_REG: begin
				wv_c    = rs_val;
				rf_we_c = 1'b1;
			end
			tce_pkg::OP_MOV_IMM: begin
				wv_c    = imm_s1;
				rf_we_c = 1'b1;
				pc_c    = pc_q + 8'd2;
			end
			tce_pkg::OP_STORE: begin
				wv_c     = rs_val;
				mem_we_c = 1'b1;
				pc_c     = pc_q + 8'd2;
			end
			tce_pkg::OP_LOAD: begin
				wv_c    = mem_val;
				rf_we_c = 1'b1;
				pc_c    = pc_q + 8'd2;
			end
			tce_pkg::OP_ADD: begin
				wv_c    = rd_val + rs_val;
				rf_we_c = 1'b1;
			end
			tce_pkg::OP_SUB: begin
				wv_c    = rd_val - rs_val;
				rf_we_c = 1'b1;
				if (wv_c == '0) begin
					flag_c = 1'b1;
				end
			end
			tce_pkg::OP_JMP: begin
				pc_c = imm_s1;
			end
			tce_pkg::OP_JEQ: begin
				if (flag_q) begin
					pc_c = imm_s1;
				end
			end
			tce_pkg::OP_HLT: begin
				halt_c = 1'b1;
				pc_c   = pc_q;
			end
			default: begin
				// Unused codes behave as no-ops that advance the PC by one.
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid   <= 1'b0;
			pc_q        <= '0;
			flag_q      <= 1'b0;
			rf_valid_q  <= '0;
			mem_valid_q <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end

			if (advance) begin
				out_valid <= 1'b1;
				pc_q      <= pc_c;
				flag_q    <= flag_c;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end

			if (rf_wr) begin
				rf_valid_q[d_s1] <= 1'b1;
			end
			if (mem_wr) begin
				mem_valid_q[a_s1] <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= tce_pkg::op_t'(operation);
			d_s1     <= d_in;
			s_s1     <= s_in;
			a_s1     <= a_in;
			imm_s1   <= operand_byte;
			fwd_d_s1 <= rf_wr && (d_s1 == d_in);
			fwd_s_s1 <= rf_wr && (d_s1 == s_in);
			fwd_m_s1 <= mem_wr && (a_s1 == a_in);
			byp_s1   <= wv_c;
		end
		if (advance) begin
			next_pc        <= pc_c;
			equal_flag_out <= flag_c;
			halted         <= halt_c;
			written_value  <= wv_c;
		end
	end

	// The input side only waits when a finished result is held up downstream.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// Every committed instruction shows up in the output register.
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("committed instruction produced no result");

	// Halt holds the program counter.
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (op_s1 == tce_pkg::OP_HLT)) |=> (next_pc == $past(pc_q)))
		else $error("halt moved the program counter");

	// The equal flag is sticky.
	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		flag_q |=> flag_q)
		else $error("equal flag cleared outside reset");

endmodule

`default_nettype wire
